[rtl/core/lidar_point_mask_labeler_macros.svh]
// ---------------------------------------------------------------------------
// Lidar point mask labeler assertion macros
// Concurrent check helpers; empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LIDAR_POINT_MASK_LABELER_MACROS_SVH
`define LIDAR_POINT_MASK_LABELER_MACROS_SVH
`ifndef SYNTHESIS
`define LPML_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lpml check failed");
`define LPML_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpml check failed");
`else
`define LPML_ASSERT(label, cond)
`define LPML_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/lpml_pkg.sv]
// ---------------------------------------------------------------------------
// Lidar point mask labeler package
// Shared types, camera matrix and register indexes.
// ---------------------------------------------------------------------------
package lpml_pkg;

  localparam int QBITS      = 11;  // quotient bits; columns above 2047 never pass
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    CFG_MAX_COL  = 2'd0,
    CFG_MAX_ROW  = 2'd1,
    CFG_NO_CLASS = 2'd2
  } lpml_cfg_idx_t;

  // Camera matrix, Q12.20, row-major 3x4
  localparam logic signed [31:0] CAM [3][4] = '{
    '{ 32'sd639311974, -32'sd756465373,   -32'sd1312040, -32'sd176054953},
    '{ 32'sd189146543,     32'sd8016153, -32'sd754609264, -32'sd106150565},
    '{   32'sd1048519,         32'sd130,      32'sd10959,    -32'sd285352}
  };

  typedef struct packed {
    logic [10:0] max_col;
    logic [8:0]  max_row;
    logic [7:0]  no_class;
  } lpml_cfg_t;

  // item between front and back
  typedef struct packed {
    logic               req;
    logic [10:0]        mcol;
    logic [8:0]         mrow;
    logic [7:0]         mclass;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [63:0] u;
    logic signed [63:0] v;
    logic signed [63:0] w;
  } lpml_item_t;

  // divider stage contents
  typedef struct packed {
    logic              req;
    logic              ok;
    logic [10:0]       mcol;
    logic [8:0]        mrow;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
    logic [7:0]        mclass;
    logic [63:0]       ru;
    logic [63:0]       rv;
    logic [63:0]       w;
    logic [QBITS-1:0]  qu;
    logic [QBITS-1:0]  qv;
  } lpml_div_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpml_fifo_st_t;

endpackage

[rtl/core/lpml_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lpml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/lpml_front.sv]
// ---------------------------------------------------------------------------
// Lidar mask labeler front end
// Accepts items, forms the three camera row sums, pushes into the queue.
// ---------------------------------------------------------------------------
module lpml_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [127:0]           in_tdata,
  input  logic                   in_tuser,
  input  lpml_pkg::lpml_fifo_st_t fifo_st,
  output logic                   push,
  output lpml_pkg::lpml_item_t   push_data
);
  import lpml_pkg::*;

  logic       adv;
  logic       f0_v_r, f1_v_r, f2_v_r;
  lpml_item_t f0_r, f1_r, f2_r, f2_nxt;
  logic signed [63:0] prod_r   [3][3];
  logic signed [63:0] prod_nxt [3][3];

  assign adv       = !fifo_st.full;
  assign in_tready = adv;
  assign push      = adv && f2_v_r;
  assign push_data = f2_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_nxt[r][0] = f0_r.x * CAM[r][0];
      prod_nxt[r][1] = f0_r.y * CAM[r][1];
      prod_nxt[r][2] = f0_r.z * CAM[r][2];
    end
  end

  always_comb begin
    f2_nxt   = f1_r;
    f2_nxt.u = prod_r[0][0] + prod_r[0][1] + prod_r[0][2] + (64'(CAM[0][3]) <<< 16);
    f2_nxt.v = prod_r[1][0] + prod_r[1][1] + prod_r[1][2] + (64'(CAM[1][3]) <<< 16);
    f2_nxt.w = prod_r[2][0] + prod_r[2][1] + prod_r[2][2] + (64'(CAM[2][3]) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f0_v_r <= in_tvalid;
      f1_v_r <= f0_v_r;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_r.req    <= in_tuser;
      f0_r.mcol   <= in_tdata[10:0];
      f0_r.mrow   <= in_tdata[19:11];
      f0_r.mclass <= in_tdata[27:20];
      f0_r.x      <= in_tdata[59:28];
      f0_r.y      <= in_tdata[91:60];
      f0_r.z      <= in_tdata[123:92];
      f0_r.u      <= '0;
      f0_r.v      <= '0;
      f0_r.w      <= '0;
      f1_r        <= f0_r;
      prod_r      <= prod_nxt;
      f2_r        <= f2_nxt;
    end
  end
endmodule

[rtl/core/lpml_fifo.sv]
// ---------------------------------------------------------------------------
// Lidar mask labeler queue
// Short queue between front and back end.
// ---------------------------------------------------------------------------
module lpml_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  lpml_pkg::lpml_item_t    push_data,
  input  logic                    pop,
  output lpml_pkg::lpml_item_t    head,
  output lpml_pkg::lpml_fifo_st_t st
);
  import lpml_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  lpml_item_t      mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign head     = mem_r[rp_r];
  assign st.full  = (cnt_r == (PW+1)'(FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule

[rtl/core/lpml_back.sv]
// ---------------------------------------------------------------------------
// Lidar mask labeler back end
// Screens points, divides by depth, checks bounds, accesses the mask.
// ---------------------------------------------------------------------------
module lpml_back #(
  parameter int IMG_WIDTH  = 1280,
  parameter int IMG_HEIGHT = 384
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lpml_pkg::lpml_fifo_st_t fifo_st,
  input  lpml_pkg::lpml_item_t    head,
  output logic                    pop,
  input  lpml_pkg::lpml_cfg_t     cfg,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [103:0]            out_tdata
);
  import lpml_pkg::*;

  localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic       adv;
  logic       s0_v_r;
  lpml_item_t s0_r;
  logic       dv_r [0:QBITS];
  lpml_div_t  div_r [0:QBITS];
  lpml_div_t  d0_nxt;

  logic            mem_v_r, mem_ok_r, mem_req_r;
  logic [AW-1:0]   mem_addr_r;
  logic [7:0]      mem_class_r;
  logic [95:0]     mem_xyz_r;
  logic            bnd_ok;
  logic [31:0]     sel_col, sel_row;

  logic            rd_v_r, rd_emit_r;
  logic [95:0]     rd_xyz_r;
  logic [7:0]      rdata;

  logic            out_v_r;
  logic [103:0]    out_r;

  assign adv        = !out_v_r || out_tready;
  assign pop        = adv && !fifo_st.empty;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // screening and divider setup
  always_comb begin
    logic u_neg, v_neg, drop;
    u_neg = s0_r.u[63];
    v_neg = s0_r.v[63];
    drop  = s0_r.x[31] || s0_r.w[63] || (s0_r.w == '0);
    drop  = drop || (u_neg && !((s0_r.u + s0_r.w) > 64'sd0));
    drop  = drop || (v_neg && !((s0_r.v + s0_r.w) > 64'sd0));
    drop  = drop || (!u_neg && ({QBITS'(0), s0_r.u} >= {s0_r.w, QBITS'(0)}));
    drop  = drop || (!v_neg && ({QBITS'(0), s0_r.v} >= {s0_r.w, QBITS'(0)}));
    d0_nxt.req    = s0_r.req;
    d0_nxt.ok     = !s0_r.req || !drop;
    d0_nxt.mcol   = s0_r.mcol;
    d0_nxt.mrow   = s0_r.mrow;
    d0_nxt.mclass = s0_r.mclass;
    d0_nxt.x      = s0_r.x;
    d0_nxt.y      = s0_r.y;
    d0_nxt.z      = s0_r.z;
    d0_nxt.ru     = u_neg ? '0 : s0_r.u;
    d0_nxt.rv     = v_neg ? '0 : s0_r.v;
    d0_nxt.w      = s0_r.w;
    d0_nxt.qu     = '0;
    d0_nxt.qv     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else if (adv) begin
      s0_v_r   <= pop;
      dv_r[0]  <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        s0_r <= head;
      end
      div_r[0] <= d0_nxt;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar gi = 0; gi < QBITS; gi++) begin : g_div
    localparam int K = QBITS - 1 - gi;
    lpml_div_t d_nxt;

    always_comb begin
      d_nxt = div_r[gi];
      if ({QBITS'(0), div_r[gi].ru} >= ({QBITS'(0), div_r[gi].w} << K)) begin
        d_nxt.ru    = div_r[gi].ru - 64'(div_r[gi].w << K);
        d_nxt.qu[K] = 1'b1;
      end
      if ({QBITS'(0), div_r[gi].rv} >= ({QBITS'(0), div_r[gi].w} << K)) begin
        d_nxt.rv    = div_r[gi].rv - 64'(div_r[gi].w << K);
        d_nxt.qv[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[gi+1] <= 1'b0;
      end else if (adv) begin
        dv_r[gi+1] <= dv_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[gi+1] <= d_nxt;
      end
    end
  end

  // bounds check and mask address
  always_comb begin
    lpml_div_t d;
    d       = div_r[QBITS];
    sel_col = d.req ? 32'(d.qu) : 32'(d.mcol);
    sel_row = d.req ? 32'(d.qv) : 32'(d.mrow);
    bnd_ok  = d.ok && (sel_col < 32'(IMG_WIDTH)) && (sel_row < 32'(IMG_HEIGHT));
    if (d.req) begin
      bnd_ok = bnd_ok && (d.qu <= cfg.max_col) && (d.qv <= QBITS'(cfg.max_row));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_v_r <= 1'b0;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      mem_v_r <= dv_r[QBITS];
      rd_v_r  <= mem_v_r;
      out_v_r <= rd_v_r && rd_emit_r && (rdata != cfg.no_class);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_ok_r    <= bnd_ok;
      mem_req_r   <= div_r[QBITS].req;
      mem_addr_r  <= AW'(sel_row * 32'(IMG_WIDTH) + sel_col);
      mem_class_r <= div_r[QBITS].mclass;
      mem_xyz_r   <= {div_r[QBITS].z, div_r[QBITS].y, div_r[QBITS].x};
      rd_emit_r   <= mem_ok_r && mem_req_r;
      rd_xyz_r    <= mem_xyz_r;
      out_r       <= {rdata, rd_xyz_r};
    end
  end

  lpml_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_mask (
    .clk   (clk),
    .we    (adv && mem_v_r && mem_ok_r && !mem_req_r),
    .waddr (mem_addr_r),
    .wdata (mem_class_r),
    .re    (adv),
    .raddr (mem_addr_r),
    .rdata (rdata)
  );
endmodule

[rtl/core/lidar_point_mask_labeler.sv]
// ---------------------------------------------------------------------------
// Lidar point mask labeler
// Labels lidar points with the class found in a camera mask image.
// ---------------------------------------------------------------------------
// Usage:
//   in_* stream carries requests. in_tuser = 0 writes one mask label at
//   (mask_col, mask_row); in_tuser = 1 projects point (pt_x, pt_y, pt_z)
//   through the fixed camera matrix, divides by depth and looks up the mask.
//   out_* stream carries labeled points: x, y, z passed through and the
//   mask label. Points that are behind, out of bounds or land on the
//   no-class label produce nothing. Mask writes produce nothing.
//   cfg_* writes max_col, max_row and no_class_value; write only when idle.
// Throughput: one item per cycle unless stalled; every stage is a single pass, the depth
//   division is an 11-stage restoring pipeline (one quotient bit a stage).
// Pipeline: 20 register stages: 3 front stages (register, multiply, sum),
//   the queue, 2 setup stages, 11 divider stages, bounds/address, mask read,
//   output reg.
// Reset: pipeline and queue empty, registers at 1225 / 369 / 255. The mask
//   is not cleared; a pixel must be written before a point reads it.
// Stall: a result held with out_tready low freezes the back end; the front
//   keeps taking items into the 4-entry queue until it fills, then
//   in_tready drops.
// ---------------------------------------------------------------------------
`include "lidar_point_mask_labeler_macros.svh"

module lidar_point_mask_labeler #(
  parameter int IMG_WIDTH  = 1280,
  parameter int IMG_HEIGHT = 384
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: mask_col[10:0] mask_row[19:11] mask_class[27:20]
  //           pt_x[59:28] pt_y[91:60] pt_z[123:92], zero above
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         in_tuser,   // req_type
  // out_tdata: out_x[31:0] out_y[63:32] out_z[95:64] out_class[103:96]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_wdata
);
  import lpml_pkg::*;

  lpml_cfg_t     cfg_r;
  lpml_fifo_st_t fifo_st;
  lpml_item_t    push_data, head;
  logic          push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_col  <= 11'd1225;
      cfg_r.max_row  <= 9'd369;
      cfg_r.no_class <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_COL:  cfg_r.max_col  <= cfg_wdata;
        CFG_MAX_ROW:  cfg_r.max_row  <= cfg_wdata[8:0];
        CFG_NO_CLASS: cfg_r.no_class <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  lpml_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_st   (fifo_st),
    .push      (push),
    .push_data (push_data)
  );

  lpml_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .st        (fifo_st)
  );

  lpml_back #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_st    (fifo_st),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // queue can never be full and empty at once
  `LPML_ASSERT(a_fifo_state, !(fifo_st.full && fifo_st.empty))
  // an emitted point never carries the no-class label
  `LPML_ASSERT(a_no_class_out, !out_tvalid || (out_tdata[103:96] != cfg_r.no_class))
  // column bound write lands in the register
  `LPML_ASSERT_NEXT(a_cfg_col, cfg_we && (cfg_index == CFG_MAX_COL), cfg_r.max_col == $past(cfg_wdata))
endmodule
